// ===== hw/rtl/rx_packet_deframer_checksum_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Shared clocked assertion forms, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef RX_PACKET_DEFRAMER_CHECKSUM_MACROS_SVH
`define RX_PACKET_DEFRAMER_CHECKSUM_MACROS_SVH

// Same-cycle implication.
`define RXDFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RXDFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rxdfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet deframer package
// Phase codes, result type and checksum helper.
// ----------------------------------------------------------------------------
package rxdfr_pkg;

  localparam logic [9:0] CheckMod    = 10'd255;
  localparam logic [9:0] CheckModTwo = 10'd510;
  localparam logic [7:0] StartReset  = 8'hFD;

  typedef enum logic [4:0] {
    PhHunt  = 5'b00001,
    PhId    = 5'b00010,
    PhHigh  = 5'b00100,
    PhLow   = 5'b01000,
    PhCheck = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       checksum_bad;
    logic [7:0] value_low;
    logic [7:0] value_high;
    logic [7:0] reg_id;
  } result_t;

  function automatic logic [7:0] check_expect(input logic [9:0] sum);
    logic [9:0] r;
    r = sum;
    if (r >= CheckModTwo) begin
      r = r - CheckModTwo;
    end
    if (r >= CheckMod) begin
      r = r - CheckMod;
    end
    return 8'(CheckMod - r);
  endfunction

endpackage

// ===== hw/rtl/rx_packet_deframer_checksum.sv =====
// ----------------------------------------------------------------------------
// Received packet deframer with checksum
// Byte stream in, one report per framed packet out, start byte via APB.
// ----------------------------------------------------------------------------
// A checksum byte's report passes the input register, then the result register.
// Throughput: one byte per cycle while not stalled; input register, collector, result register.
// A held result stalls only a checksum byte; other bytes keep flowing.
// Reset: hunting for the start byte, start byte register 0xFD.

module rx_packet_deframer_checksum import rxdfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] reg_id, [15:8] value_high, [23:16] value_low
  output logic        m_axis_tuser,   // [0] checksum_bad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic [7:0] start_q;
  logic       out_vld_q, out_vld_d;
  result_t    out_res_q;
  logic       advance;
  logic       emit;
  result_t    res;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {24'b0, start_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartReset;
    end else if (cfg_we) begin
      start_q <= pwdata[7:0];
    end
  end

  rxdfr_collect u_collect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .start_byte_i (start_q),
    .emit_o       (emit),
    .result_o     (res)
  );

  assign advance       = in_vld_q && (!emit || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready) begin
      in_vld_d = s_axis_tvalid;
    end
    out_vld_d = out_vld_q;
    if (advance && emit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && emit) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_res_q.value_low, out_res_q.value_high, out_res_q.reg_id};
  assign m_axis_tuser  = out_res_q.checksum_bad;

endmodule

// ===== hw/rtl/rxdfr_collect.sv =====
// ----------------------------------------------------------------------------
// Packet collector
// Hunts for the start byte, gathers the payload and checks the checksum byte.
// ----------------------------------------------------------------------------
`include "rx_packet_deframer_checksum_macros.svh"

module rxdfr_collect import rxdfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] start_byte_i,
  output logic       emit_o,
  output result_t    result_o
);

  phase_e     phase_q, phase_d;
  logic [9:0] sum_q, sum_d;
  logic [7:0] id_q, id_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    id_d    = id_q;
    high_d  = high_q;
    low_d   = low_q;
    if (step_i) begin
      unique case (phase_q)
        PhId: begin
          id_d    = byte_i;
          sum_d   = sum_q + 10'(byte_i);
          phase_d = PhHigh;
        end
        PhHigh: begin
          high_d  = byte_i;
          sum_d   = sum_q + 10'(byte_i);
          phase_d = PhLow;
        end
        PhLow: begin
          low_d   = byte_i;
          sum_d   = sum_q + 10'(byte_i);
          phase_d = PhCheck;
        end
        PhCheck: begin
          sum_d   = '0;
          phase_d = PhHunt;
        end
        default: begin
          if (byte_i == start_byte_i) begin
            phase_d = PhId;
            sum_d   = '0;
          end else begin
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sum_q   <= '0;
      id_q    <= '0;
      high_q  <= '0;
      low_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      id_q    <= id_d;
      high_q  <= high_d;
      low_q   <= low_d;
    end
  end

  assign emit_o                = (phase_q == PhCheck);
  assign result_o.reg_id       = id_q;
  assign result_o.value_high   = high_q;
  assign result_o.value_low    = low_q;
  assign result_o.checksum_bad = (check_expect(sum_q) != byte_i);

  `RXDFR_ASSERT_NEXT(a_back_to_hunt, step_i && emit_o, phase_q == PhHunt && sum_q == '0,
    "collector did not return to hunting after the checksum byte")
  `RXDFR_ASSERT_NEXT(a_low_then_check, step_i && phase_q == PhLow, emit_o,
    "collector skipped the checksum byte")
  `RXDFR_ASSERT_NEXT(a_open_packet,
    step_i && phase_q == PhHunt && byte_i == start_byte_i,
    phase_q == PhId && sum_q == '0,
    "start byte did not open a packet")
  `RXDFR_ASSERT_NOW(a_sum_bound, emit_o, sum_q <= 10'd765,
    "payload sum out of range")

endmodule

// ===== verif/tb_rx_packet_deframer_checksum.sv =====
// ----------------------------------------------------------------------------
// Testbench for the received packet deframer with checksum
// Streams framed and noisy bytes into the block, predicts one report per
// packet from a local copy of the deframing state and the start byte, and
// compares every report field against the oldest prediction. The start byte
// is rewritten over APB between traffic phases, the receiver is throttled at
// varying rates, and one long receiver hold-off forces input backpressure.
// ----------------------------------------------------------------------------
module tb_rx_packet_deframer_checksum import rxdfr_pkg::*; ();

  localparam logic [2:0]  ADDR_START_BYTE = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED     = 3'd4;
  localparam int unsigned CHECK_MODULUS   = 255;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          STALL_LIMIT     = 4000;
  localparam int          PHASE_BYTES     = 420;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] reg_id, [15:8] value_high, [23:16] value_low
  logic        m_axis_tuser;           // [0] checksum_bad
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  rx_packet_deframer_checksum i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  logic [7:0] rx_byte_q[$];
  result_t    report_q[$];
  logic       rx_taken    = 1'b0;
  int         send_idle   = 0;
  int         recv_idle   = 0;
  int         hold_req    = 0;
  int         hold_ack    = 0;
  int         hold_left   = 0;
  int         mismatches  = 0;
  int         stall_count = 0;

  // Predicted deframer state.
  phase_e     frame_phase = PhHunt;
  logic [7:0] start_byte  = StartReset;
  logic [7:0] id_hold     = 8'h00;
  logic [7:0] high_hold   = 8'h00;
  logic [7:0] low_hold    = 8'h00;
  logic [9:0] payload_sum = 10'd0;

  function automatic logic [7:0] checksum_of(input int unsigned sum);
    return 8'(CHECK_MODULUS - (sum % CHECK_MODULUS));
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    result_t rep;
    case (frame_phase)
      PhId: begin
        id_hold     = b;
        payload_sum = payload_sum + 10'(b);
        frame_phase = PhHigh;
      end
      PhHigh: begin
        high_hold   = b;
        payload_sum = payload_sum + 10'(b);
        frame_phase = PhLow;
      end
      PhLow: begin
        low_hold    = b;
        payload_sum = payload_sum + 10'(b);
        frame_phase = PhCheck;
      end
      PhCheck: begin
        rep.reg_id       = id_hold;
        rep.value_high   = high_hold;
        rep.value_low    = low_hold;
        rep.checksum_bad = (checksum_of(payload_sum) != b);
        report_q = {report_q, rep};
        frame_phase = PhHunt;
        payload_sum = 10'd0;
      end
      default: begin
        if (b == start_byte) begin
          frame_phase = PhId;
          payload_sum = 10'd0;
        end else begin
          frame_phase = PhHunt;
        end
      end
    endcase
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Byte driver: hold a request until taken, idle only between requests.
  always @(negedge clk_i) begin
    if (!rst_ni || rx_byte_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !rx_taken) begin
      s_axis_tdata <= rx_byte_q[0];
    end else if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= rx_byte_q[0];
    end
  end

  always @(posedge clk_i) begin
    rx_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      deframe_byte(s_axis_tdata);
      void'(rx_byte_q.pop_front());
    end
  end

  // Report receiver with optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.reg_id       = m_axis_tdata[7:0];
      got.value_high   = m_axis_tdata[15:8];
      got.value_low    = m_axis_tdata[23:16];
      got.checksum_bad = m_axis_tuser;
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report id=%h hi=%h lo=%h bad=%b", $time,
                 got.reg_id, got.value_high, got.value_low, got.checksum_bad);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        if (got.reg_id !== want.reg_id || got.value_high !== want.value_high ||
            got.value_low !== want.value_low || got.checksum_bad !== want.checksum_bad) begin
          $display("%0t: report mismatch expected %h %h %h %b actual %h %h %h %b",
                   $time, want.reg_id, want.value_high, want.value_low, want.checksum_bad,
                   got.reg_id, got.value_high, got.value_low, got.checksum_bad);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_START_BYTE) begin
      start_byte = val;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [7:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== want) begin
      $display("%0t: start byte readback expected %h actual %h", $time, want, prdata[7:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_start_byte(input logic [7:0] val);
    apb_write(ADDR_START_BYTE, val);
    apb_read_check(ADDR_START_BYTE, val);
  endtask

  task automatic drain();
    while (rx_byte_q.size() != 0 || report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_bytes(input logic [7:0] bytes[]);
    foreach (bytes[i]) rx_byte_q = {rx_byte_q, bytes[i]};
  endtask

  task automatic queue_packet();
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned sel;
    logic [7:0]  chk;
    a   = $urandom_range(255);
    b   = $urandom_range(255);
    c   = $urandom_range(255);
    sel = $urandom_range(99);
    if (sel < 12) begin
      c = (CHECK_MODULUS - ((a + b) % CHECK_MODULUS)) % CHECK_MODULUS;
    end
    chk = checksum_of(a + b + c);
    if ($urandom_range(99) < 35) begin
      chk = ($urandom_range(3) == 0) ? ~chk : 8'($urandom);
    end
    rx_byte_q = {rx_byte_q, start_byte, 8'(a), 8'(b), 8'(c), chk};
  endtask

  task automatic queue_traffic(input int target);
    int framed;
    int n;
    framed = 0;
    while (framed < target) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) rx_byte_q = {rx_byte_q, 8'($urandom)};
      end
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 3);
        rx_byte_q = {rx_byte_q, start_byte};
        repeat (n) rx_byte_q = {rx_byte_q, 8'($urandom)};
        framed += n + 1;
      end else begin
        queue_packet();
        framed += 5;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_read_check(ADDR_START_BYTE, StartReset);

    // Directed: noise, zero-sum packet, start byte as data, extreme payloads.
    queue_bytes('{8'h00, 8'hFF,
                  8'hFD, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'hFD, 8'hFD, 8'hFF, 8'hFF, 8'h02,
                  8'hFD, 8'h01, 8'h02});
    drain();
    // Rewrite the start byte with a packet still open.
    set_start_byte(8'h00);
    queue_bytes('{8'h03, 8'h07});
    drain();
    apb_write(ADDR_UNUSED, 8'h55);
    apb_read_check(ADDR_START_BYTE, 8'h00);
    queue_bytes('{8'hFD, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00});
    drain();

    send_idle = 17;
    recv_idle = 73;
    set_start_byte(8'hFF);
    queue_traffic(PHASE_BYTES);
    drain();

    send_idle = 73;
    recv_idle = 17;
    set_start_byte(8'($urandom));
    queue_traffic(PHASE_BYTES);
    drain();

    send_idle = 0;
    recv_idle = 0;
    set_start_byte(8'h00);
    hold_req = hold_req + 1;
    queue_traffic(PHASE_BYTES);
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rxdfr_pkg.sv
hw/rtl/rxdfr_collect.sv
hw/rtl/rx_packet_deframer_checksum.sv
verif/tb_rx_packet_deframer_checksum.sv
